// ===== hdl/mxt_pkg.sv =====
// shared types and constants for the maximum-xor counted trie
// no dependencies; imported by every module of the block but mxt_ram
package mxt_pkg;

   localparam int KEY_BITS   = 20;
   localparam int MAX_NODES  = 16384;
   localparam int COUNT_BITS = 16;

   localparam int NODE_BITS    = $clog2(MAX_NODES);
   localparam int USE_BITS     = $clog2(MAX_NODES + 1);
   localparam int LEVEL_BITS   = $clog2(KEY_BITS + 1);
   localparam int KEY_IDX_BITS = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int TOTAL_BITS   = COUNT_BITS + 1;
   localparam int CFG_BITS     = 5;
   localparam int OP_BITS      = 2;
   localparam int STATUS_BITS  = 2;

   localparam logic [CFG_BITS-1:0] BIT_COUNT_RESET = CFG_BITS'(20);

   // opcodes
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]  opcode;
      logic [KEY_BITS-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]    xor_max;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   // result offered by the walker to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   // both child links of one node, indexed by the key bit; zero means absent
   typedef logic [1:0][NODE_BITS-1:0] link_pair_type;

endpackage

// ===== hdl/mxt_ram.sv =====
// generic single-write, single-read synchronous ram with a registered read
// no dependencies
module mxt_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/mxt_walker.sv =====
// trie walk sequencer: check and update passes, node allocation, greedy query
// depends on mxt_pkg and mxt_ram (link table and count table)
module mxt_walker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mxt_pkg::CFG_BITS-1:0]   bit_count,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mxt_pkg::req_type               req_data,
   output mxt_pkg::res_type               res,
   input  logic                           res_take
);

   import mxt_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CHK   = 8'b0000_0010,
      S_UPD   = 8'b0000_0100,
      S_FILL  = 8'b0000_1000,
      S_QSTEP = 8'b0001_0000,
      S_QOPP  = 8'b0010_0000,
      S_QSAME = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } walk_state_type;

   localparam logic [USE_BITS:0]   NODE_LIMIT = (USE_BITS + 1)'(MAX_NODES);
   localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

   walk_state_type            state_ff, state_in;
   logic [OP_BITS-1:0]        op_ff, op_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic [LEVEL_BITS-1:0]     nb_ff, nb_in;
   logic [LEVEL_BITS-1:0]     rem_ff, rem_in;
   logic [NODE_BITS-1:0]      cur_ff, cur_in;
   logic                      fresh_ff, fresh_in;
   link_pair_type             links_ff, links_in;
   logic [KEY_BITS-1:0]       acc_ff, acc_in;
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   link_pair_type             root_ff, root_in;
   logic [USE_BITS-1:0]       used_ff, used_in;
   logic [TOTAL_BITS-1:0]     total_ff, total_in;

   // table ports
   logic                      rd_en;
   logic [NODE_BITS-1:0]      rd_addr;
   link_pair_type             rd_links;
   logic [COUNT_BITS-1:0]     rd_count;
   logic                      link_we;
   logic [NODE_BITS-1:0]      link_waddr;
   link_pair_type             link_wdata;
   logic                      cnt_we;
   logic [NODE_BITS-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0]     cnt_wdata;

   logic [LEVEL_BITS-1:0]     eff_bits;
   logic [LEVEL_BITS-1:0]     lvl;
   logic [LEVEL_BITS-1:0]     rem_dec;
   logic                      bit_sel;
   link_pair_type             node_links;
   logic [NODE_BITS-1:0]      nxt;
   logic [NODE_BITS-1:0]      opp;
   logic [NODE_BITS-1:0]      same;
   logic [NODE_BITS-1:0]      alloc_node;
   link_pair_type             alloc_links;
   link_pair_type             fill_links;
   logic [USE_BITS:0]         need_nodes;
   logic                      is_ins;

   mxt_ram #(.DEPTH(MAX_NODES), .WIDTH(2 * NODE_BITS)) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_links)
   );

   mxt_ram #(.DEPTH(MAX_NODES), .WIDTH(COUNT_BITS)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_count)
   );

   // effective key length, clamped to 1..KEY_BITS
   always_comb begin
      if (bit_count == '0) begin
         eff_bits = LEVEL_BITS'(1);
      end else if (int'(bit_count) > KEY_BITS) begin
         eff_bits = LEVEL_BITS'(KEY_BITS);
      end else begin
         eff_bits = LEVEL_BITS'(bit_count);
      end
   end

   assign rem_dec     = rem_ff - LEVEL_BITS'(1);
   assign lvl         = rem_dec;
   assign bit_sel     = key_ff[lvl[KEY_IDX_BITS-1:0]];
   assign node_links  = fresh_ff ? rd_links : links_ff;
   assign nxt         = node_links[bit_sel];
   assign opp         = links_ff[~bit_sel];
   assign same        = links_ff[bit_sel];
   assign alloc_node  = used_ff[NODE_BITS-1:0];
   assign need_nodes  = {1'b0, used_ff} + (USE_BITS + 1)'(rem_ff);
   assign is_ins      = (op_ff == OP_INSERT);

   always_comb begin
      alloc_links          = node_links;
      alloc_links[bit_sel] = alloc_node;
      fill_links           = '0;
      if (rem_ff != '0) begin
         fill_links[bit_sel] = alloc_node;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res       = '{valid: (state_ff == S_DONE),
                        data: '{xor_max: acc_ff, status: status_ff}};

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      nb_in      = nb_ff;
      rem_in     = rem_ff;
      cur_in     = cur_ff;
      fresh_in   = fresh_ff;
      links_in   = links_ff;
      acc_in     = acc_ff;
      status_in  = status_ff;
      root_in    = root_ff;
      used_in    = used_ff;
      total_in   = total_ff;
      rd_en      = 1'b0;
      rd_addr    = nxt;
      link_we    = 1'b0;
      link_waddr = cur_ff;
      link_wdata = alloc_links;
      cnt_we     = 1'b0;
      cnt_waddr  = cur_ff;
      cnt_wdata  = is_ins ? rd_count + COUNT_BITS'(1) : rd_count - COUNT_BITS'(1);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               key_in    = req_data.key_value;
               nb_in     = eff_bits;
               rem_in    = eff_bits;
               fresh_in  = 1'b0;
               links_in  = root_ff;
               acc_in    = '0;
               status_in = ST_OK;
               case (req_data.opcode)
                  OP_INSERT, OP_REMOVE: begin
                     state_in = S_CHK;
                  end
                  OP_QUERY: begin
                     if (total_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_QSTEP;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // read-only pass: path counts must allow the change
         S_CHK: begin
            if (fresh_ff && is_ins && rd_count == CNT_MAX) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else if (fresh_ff && !is_ins && rd_count == '0) begin
               status_in = ST_ABSENT;
               state_in  = S_DONE;
            end else if (rem_ff == '0) begin
               rem_in   = nb_ff;
               fresh_in = 1'b0;
               links_in = root_ff;
               state_in = S_UPD;
            end else if (nxt == '0) begin
               if (!is_ins) begin
                  status_in = ST_ABSENT;
                  state_in  = S_DONE;
               end else if (need_nodes > NODE_LIMIT) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  rem_in   = nb_ff;
                  fresh_in = 1'b0;
                  links_in = root_ff;
                  state_in = S_UPD;
               end
            end else begin
               rd_en    = 1'b1;
               cur_in   = nxt;
               fresh_in = 1'b1;
               rem_in   = rem_dec;
            end
         end

         // write pass: count of the node just read, then step or allocate
         S_UPD: begin
            cnt_we = fresh_ff;
            if (rem_ff == '0) begin
               total_in = is_ins ? total_ff + TOTAL_BITS'(1) : total_ff - TOTAL_BITS'(1);
               state_in = S_DONE;
            end else if (nxt != '0) begin
               rd_en    = 1'b1;
               cur_in   = nxt;
               fresh_in = 1'b1;
               rem_in   = rem_dec;
            end else if (is_ins) begin
               if (fresh_ff) begin
                  link_we = 1'b1;
               end else begin
                  root_in = alloc_links;
               end
               cur_in   = alloc_node;
               used_in  = used_ff + USE_BITS'(1);
               fresh_in = 1'b0;
               rem_in   = rem_dec;
               state_in = S_FILL;
            end else begin
               status_in = ST_ABSENT;
               state_in  = S_DONE;
            end
         end

         // fresh nodes: chain to the next new node, count one
         S_FILL: begin
            link_we    = 1'b1;
            link_wdata = fill_links;
            cnt_we     = 1'b1;
            cnt_wdata  = COUNT_BITS'(1);
            if (rem_ff == '0) begin
               total_in = total_ff + TOTAL_BITS'(1);
               state_in = S_DONE;
            end else begin
               cur_in  = alloc_node;
               used_in = used_ff + USE_BITS'(1);
               rem_in  = rem_dec;
            end
         end

         S_QSTEP: begin
            if (rem_ff == '0) begin
               state_in = S_DONE;
            end else if (opp != '0) begin
               rd_en    = 1'b1;
               rd_addr  = opp;
               state_in = S_QOPP;
            end else if (same != '0) begin
               rd_en    = 1'b1;
               rd_addr  = same;
               state_in = S_QSAME;
            end else begin
               acc_in = {acc_ff[KEY_BITS-2:0], 1'b0};
               rem_in = rem_dec;
            end
         end

         S_QOPP: begin
            if (rd_count != '0) begin
               acc_in   = {acc_ff[KEY_BITS-2:0], 1'b1};
               links_in = rd_links;
               rem_in   = rem_dec;
               state_in = S_QSTEP;
            end else if (same != '0) begin
               rd_en    = 1'b1;
               rd_addr  = same;
               state_in = S_QSAME;
            end else begin
               acc_in   = {acc_ff[KEY_BITS-2:0], 1'b0};
               rem_in   = rem_dec;
               state_in = S_QSTEP;
            end
         end

         S_QSAME: begin
            acc_in   = {acc_ff[KEY_BITS-2:0], 1'b0};
            links_in = rd_links;
            rem_in   = rem_dec;
            state_in = S_QSTEP;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         root_ff  <= '0;
         used_ff  <= USE_BITS'(1);
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         root_ff  <= root_in;
         used_ff  <= used_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      nb_ff     <= nb_in;
      rem_ff    <= rem_in;
      cur_ff    <= cur_in;
      fresh_ff  <= fresh_in;
      links_ff  <= links_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
   end

endmodule

// ===== hdl/max_xor_counted_trie_top.sv =====
// top level of the maximum-xor counted trie: config register, output register
// depends on mxt_pkg and mxt_walker
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   req     | in        | req_valid/req_stall | opcode, key_value
//   rsp     | out       | rsp_valid/rsp_stall | xor_max, status
//   csr     | in        | csr_valid/csr_ready | bit_count (always ready)
//
// one item at a time; insert and remove run a check pass and an update pass
// over the effective key bits, one trie level a cycle, from transfer to the
// result register; error exits end early
// a query reads at each level the opposite child, if present, and possibly the
// same child through the single read port of the node tables
// the next item is taken in the idle state entered after the result leaves the walker
// reset is synchronous; node tables need no clearing, only the root links,
// node fill count and key total are cleared, so items are taken right away
// a finished result sits in the output register while the next item runs
module max_xor_counted_trie_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  mxt_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output mxt_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mxt_pkg::CFG_BITS-1:0] csr_data
);

   import mxt_pkg::*;

   logic [CFG_BITS-1:0] bit_count_ff, bit_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   res_type             res;
   logic                res_take;

   // config register takes a transfer in any cycle
   assign csr_ready = 1'b1;

   always_comb begin
      bit_count_in = bit_count_ff;
      if (csr_valid) begin
         bit_count_in = csr_data;
      end
   end

   mxt_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .bit_count (bit_count_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res       (res),
      .res_take  (res_take)
   );

   // output register: loads when empty or when its result moves on
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= BIT_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_count_ff <= bit_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/mxt_check.sv =====
// port-level assertions for the maximum-xor counted trie, bound to the top
// depends on mxt_pkg and max_xor_counted_trie_top
module mxt_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mxt_pkg::rsp_type rsp_data
);

   import mxt_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // any error status carries a zero answer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.xor_max == '0)
      else $error("error status with nonzero xor");

   // an accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken back to back");

endmodule

bind max_xor_counted_trie_top mxt_check u_check (.*);
